[src/k_way_merge_min_heap_core_macros.svh]
// ----------------------------------------------------------------------------
// k_way_merge_min_heap_core_macros
// Assertion macros shared by the heap core.
// ----------------------------------------------------------------------------
`ifndef K_WAY_MERGE_MIN_HEAP_CORE_MACROS_SVH
`define K_WAY_MERGE_MIN_HEAP_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define KWM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way merge heap core.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SRC_W  = 6;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned OCC_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_PUSH  = 2'd1,
        OP_TAKE  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP_CHK,
        S_UP_CMP,
        S_TAKE_WAIT,
        S_DOWN_RD,
        S_DOWN_CMP,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    load;        // latch input word
        logic    clear;       // empty the heap
        logic    push_start;  // hole at count, count++
        logic    take_start;  // read root and last, count--
        logic    take_load;   // root -> result, last -> moving entry
        logic    up_read;     // read parent of hole
        logic    up_move;     // parent into hole, climb, read next parent
        logic    down_read;   // read both children of hole
        logic    down_move;   // best child into hole, descend, read its children
        logic    wr_item;     // moving entry into hole
        logic    res_set;     // set result status
        t_status res_status;
        logic    out_load;    // result -> output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_opcode op;
        logic    full;
        logic    empty;
        logic    idx_zero;
        logic    parent_zero;
        logic    item_lt_a;
        logic    down_more;
        logic    down_go;
        logic    down_more_next;
    } t_dp_stat;

endpackage

[src/kwm_ram.sv]
// ----------------------------------------------------------------------------
// kwm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
    parameter int unsigned WIDTH = 38,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[src/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer for clear, push (sift up) and take (sift down).
// ----------------------------------------------------------------------------
module kwm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  kwm_pkg::t_dp_stat i_stat,
    output kwm_pkg::t_dp_cmd  o_cmd
);

    kwm_pkg::t_state r_state;
    kwm_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kwm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            kwm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kwm_pkg::S_DECODE;
                end
            end
            kwm_pkg::S_DECODE: begin
                unique case (i_stat.op)
                    kwm_pkg::OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = kwm_pkg::S_DONE;
                    end
                    kwm_pkg::OP_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = kwm_pkg::ST_FULL;
                            n_state          = kwm_pkg::S_DONE;
                        end else begin
                            o_cmd.push_start = 1'b1;
                            n_state          = kwm_pkg::S_UP_CHK;
                        end
                    end
                    kwm_pkg::OP_TAKE: begin
                        if (i_stat.empty) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = kwm_pkg::ST_EMPTY;
                            n_state          = kwm_pkg::S_DONE;
                        end else begin
                            o_cmd.take_start = 1'b1;
                            n_state          = kwm_pkg::S_TAKE_WAIT;
                        end
                    end
                    default: begin
                        n_state = kwm_pkg::S_DONE;
                    end
                endcase
            end
            kwm_pkg::S_UP_CHK: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_item = 1'b1;
                    n_state       = kwm_pkg::S_DONE;
                end else begin
                    o_cmd.up_read = 1'b1;
                    n_state       = kwm_pkg::S_UP_CMP;
                end
            end
            kwm_pkg::S_UP_CMP: begin
                if (i_stat.item_lt_a) begin
                    o_cmd.up_move = 1'b1;
                    if (i_stat.parent_zero) begin
                        n_state = kwm_pkg::S_UP_CHK;
                    end
                end else begin
                    o_cmd.wr_item = 1'b1;
                    n_state       = kwm_pkg::S_DONE;
                end
            end
            kwm_pkg::S_TAKE_WAIT: begin
                o_cmd.take_load = 1'b1;
                n_state = i_stat.empty ? kwm_pkg::S_DONE : kwm_pkg::S_DOWN_RD;
            end
            kwm_pkg::S_DOWN_RD: begin
                if (i_stat.down_more) begin
                    o_cmd.down_read = 1'b1;
                    n_state         = kwm_pkg::S_DOWN_CMP;
                end else begin
                    o_cmd.wr_item = 1'b1;
                    n_state       = kwm_pkg::S_DONE;
                end
            end
            kwm_pkg::S_DOWN_CMP: begin
                if (i_stat.down_go) begin
                    o_cmd.down_move = 1'b1;
                    if (!i_stat.down_more_next) begin
                        n_state = kwm_pkg::S_DOWN_RD;
                    end
                end else begin
                    o_cmd.wr_item = 1'b1;
                    n_state       = kwm_pkg::S_DONE;
                end
            end
            kwm_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = kwm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kwm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == kwm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[src/kwm_datapath.sv]
// ----------------------------------------------------------------------------
// kwm_datapath
// Heap store, hole index, moving entry, count and result registers.
// ----------------------------------------------------------------------------
module kwm_datapath #(
    parameter int unsigned CAPACITY    = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kwm_pkg::t_dp_cmd             i_cmd,
    output kwm_pkg::t_dp_stat            o_stat,
    input  logic [kwm_pkg::OP_W-1:0]     i_opcode,
    input  logic [kwm_pkg::DATA_W-1:0]   i_value,
    input  logic [kwm_pkg::SRC_W-1:0]    i_source,
    output logic [kwm_pkg::DATA_W-1:0]   o_out_value,
    output logic [kwm_pkg::SRC_W-1:0]    o_out_source,
    output logic [kwm_pkg::ST_W-1:0]     o_status,
    output logic [kwm_pkg::OCC_W-1:0]    o_occupancy
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned SW = kwm_pkg::SRC_W;
    localparam int unsigned EW = VALUE_WIDTH + SW;
    localparam int unsigned XW = AW + 2;
    localparam int unsigned DW = kwm_pkg::DATA_W;
    localparam int unsigned OW = kwm_pkg::OCC_W;

    // value first, then lower source
    function automatic logic entry_less(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic signed [VALUE_WIDTH-1:0] a_val;
        logic signed [VALUE_WIDTH-1:0] b_val;
        logic [SW-1:0]                 a_src;
        logic [SW-1:0]                 b_src;
        a_val = a[EW-1:SW];
        b_val = b[EW-1:SW];
        a_src = a[SW-1:0];
        b_src = b[SW-1:0];
        return (a_val < b_val) || ((a_val == b_val) && (a_src < b_src));
    endfunction

    kwm_pkg::t_opcode        r_op,         n_op;
    logic [EW-1:0]           r_item,       n_item;
    logic [AW-1:0]           r_idx,        n_idx;
    logic [CW-1:0]           r_count,      n_count;
    logic [VALUE_WIDTH-1:0]  r_res_value,  n_res_value;
    logic [SW-1:0]           r_res_source, n_res_source;
    kwm_pkg::t_status        r_res_status, n_res_status;
    logic [DW-1:0]           r_out_value;
    logic [SW-1:0]           r_out_source;
    kwm_pkg::t_status        r_out_status;
    logic [OW-1:0]           r_out_occ;

    logic [VALUE_WIDTH+DW-1:0] w_val_in_wide;
    logic [VALUE_WIDTH+DW-1:0] w_val_out_wide;
    logic [CW+OW-1:0]          w_occ_wide;
    logic [EW-1:0]             w_item_in;

    logic [AW-1:0] w_idx_m1;
    logic [AW-1:0] w_parent;
    logic [AW-1:0] w_par_m1;
    logic [AW-1:0] w_gparent;
    logic [CW-1:0] w_last;
    logic [XW-1:0] w_count_x;
    logic [XW-1:0] w_left;
    logic [XW-1:0] w_right;
    logic [XW-1:0] w_best_left;
    logic [XW-1:0] w_best_right;
    logic [AW-1:0] w_best_idx;
    logic [EW-1:0] w_best;
    logic          w_pick_right;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [AW-1:0] w_raddr_a;
    logic [AW-1:0] w_raddr_b;
    logic [EW-1:0] w_rdata_a;
    logic [EW-1:0] w_rdata_b;

    kwm_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // input value: low VALUE_WIDTH bits of the zero-extended port
    assign w_val_in_wide  = {{VALUE_WIDTH{1'b0}}, i_value};
    assign w_item_in      = {w_val_in_wide[VALUE_WIDTH-1:0], i_source};
    assign w_val_out_wide = {{DW{1'b0}}, r_res_value};
    assign w_occ_wide     = {{OW{1'b0}}, r_count};

    // heap index arithmetic
    assign w_idx_m1  = r_idx - 1'b1;
    assign w_parent  = w_idx_m1 >> 1;
    assign w_par_m1  = w_parent - 1'b1;
    assign w_gparent = w_par_m1 >> 1;
    assign w_last    = r_count - 1'b1;
    assign w_count_x = XW'(r_count);
    assign w_left    = {1'b0, r_idx, 1'b1};
    assign w_right   = w_left + 1'b1;

    // child pick, left wins ties
    assign w_pick_right = (w_right < w_count_x) && entry_less(w_rdata_b, w_rdata_a);
    assign w_best       = w_pick_right ? w_rdata_b : w_rdata_a;
    assign w_best_idx   = w_pick_right ? w_right[AW-1:0] : w_left[AW-1:0];
    assign w_best_left  = {1'b0, w_best_idx, 1'b1};
    assign w_best_right = w_best_left + 1'b1;

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = r_item;
        w_raddr_a = '0;
        w_raddr_b = '0;
        if (i_cmd.take_start) begin
            w_raddr_b = w_last[AW-1:0];
        end
        if (i_cmd.up_read) begin
            w_raddr_a = w_parent;
        end
        if (i_cmd.up_move) begin
            w_raddr_a = w_gparent;
            w_we      = 1'b1;
            w_wdata   = w_rdata_a;
        end
        if (i_cmd.down_read) begin
            w_raddr_a = w_left[AW-1:0];
            w_raddr_b = w_right[AW-1:0];
        end
        if (i_cmd.down_move) begin
            w_raddr_a = w_best_left[AW-1:0];
            w_raddr_b = w_best_right[AW-1:0];
            w_we      = 1'b1;
            w_wdata   = w_best;
        end
        if (i_cmd.wr_item) begin
            w_we = 1'b1;
        end
    end

    always_comb begin
        n_op         = r_op;
        n_item       = r_item;
        n_idx        = r_idx;
        n_count      = r_count;
        n_res_value  = r_res_value;
        n_res_source = r_res_source;
        n_res_status = r_res_status;

        if (i_cmd.load) begin
            n_op         = kwm_pkg::t_opcode'(i_opcode);
            n_item       = w_item_in;
            n_res_value  = '0;
            n_res_source = '0;
            n_res_status = kwm_pkg::ST_OK;
        end
        if (i_cmd.res_set) begin
            n_res_status = i_cmd.res_status;
        end

        priority if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push_start) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.take_start) begin
            n_count = w_last;
        end else begin
            n_count = r_count;
        end

        priority if (i_cmd.push_start) begin
            n_idx = r_count[AW-1:0];
        end else if (i_cmd.take_load) begin
            n_idx = '0;
        end else if (i_cmd.up_move) begin
            n_idx = w_parent;
        end else if (i_cmd.down_move) begin
            n_idx = w_best_idx;
        end else begin
            n_idx = r_idx;
        end

        if (i_cmd.take_load) begin
            n_item       = w_rdata_b;
            n_res_value  = w_rdata_a[EW-1:SW];
            n_res_source = w_rdata_a[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_item       <= n_item;
        r_idx        <= n_idx;
        r_res_value  <= n_res_value;
        r_res_source <= n_res_source;
        r_res_status <= n_res_status;
        if (i_cmd.out_load) begin
            r_out_value  <= w_val_out_wide[DW-1:0];
            r_out_source <= r_res_source;
            r_out_status <= r_res_status;
            r_out_occ    <= w_occ_wide[OW-1:0];
        end
    end

    assign o_stat.op             = r_op;
    assign o_stat.full           = (r_count == CW'(CAPACITY));
    assign o_stat.empty          = (r_count == '0);
    assign o_stat.idx_zero       = (r_idx == '0);
    assign o_stat.parent_zero    = (w_parent == '0);
    assign o_stat.item_lt_a      = entry_less(r_item, w_rdata_a);
    assign o_stat.down_more      = (w_left < w_count_x);
    assign o_stat.down_go        = entry_less(w_best, r_item);
    assign o_stat.down_more_next = (w_best_left < w_count_x);

    assign o_out_value  = r_out_value;
    assign o_out_source = r_out_source;
    assign o_status     = r_out_status;
    assign o_occupancy  = r_out_occ;

endmodule

[src/k_way_merge_min_heap_core.sv]
// Sequencing: clear and nop go from decode straight to the result; push sifts up
//   level by level and take sifts down level by level, through the heap RAM
//   compare loop that issues one read per level.
// Throughput: one word in flight; the next word is taken once the result is parked.
// Reset: synchronous active-low clears the entry count, sequencer and output valid;
//   the heap store needs no clearing pass since only held entries are ever used.
// ----------------------------------------------------------------------------
// k_way_merge_min_heap_core
// Min-heap core for a k-way merge: clear, push {value, source}, take minimum.
// ----------------------------------------------------------------------------
`include "k_way_merge_min_heap_core_macros.svh"

module k_way_merge_min_heap_core #(
    parameter int unsigned CAPACITY    = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input word: one heap operation
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [kwm_pkg::OP_W-1:0]     i_opcode,
    input  logic [kwm_pkg::DATA_W-1:0]   i_value,
    input  logic [kwm_pkg::SRC_W-1:0]    i_source,
    // result word: one per operation
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [kwm_pkg::DATA_W-1:0]   o_out_value,
    output logic [kwm_pkg::SRC_W-1:0]    o_out_source,
    output logic [kwm_pkg::ST_W-1:0]     o_status,
    output logic [kwm_pkg::OCC_W-1:0]    o_occupancy
);

    localparam int unsigned OCC_W = kwm_pkg::OCC_W;
    // occupancy reported when a push bounces off a full heap
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

    kwm_pkg::t_dp_cmd  w_cmd;
    kwm_pkg::t_dp_stat w_stat;

    // Sequencer: decode, then sift up (push) or sift down (take).
    // Each level is one pass of the compare state: read data of the current
    // level is compared while the next level's read is issued and the hole moves.
    kwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath: heap RAM (1 write, 2 registered reads), hole index,
    // moving entry, count, result and output registers.
    kwm_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .i_source     (i_source),
        .o_out_value  (o_out_value),
        .o_out_source (o_out_source),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    // terms for the checks below
    logic w_in_acc;
    logic w_empty_res;
    logic w_empty_ok;
    logic w_full_res;
    logic w_full_ok;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_empty_res = o_out_valid && (o_status == kwm_pkg::ST_EMPTY);
    assign w_empty_ok  = (o_out_value == '0) && (o_out_source == '0) && (o_occupancy == '0);
    assign w_full_res  = o_out_valid && (o_status == kwm_pkg::ST_FULL);
    assign w_full_ok   = (o_occupancy == OCC_FULL) && (o_out_value == '0);

    // one word at a time: after an accept the sequencer is busy
    `KWM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_acc, !o_in_ready, "busy after accept")

    // a take from an empty heap returns zeros and no entries
    `KWM_ASSERT_IMPLIES(a_empty_result, i_clk, i_rst_n, w_empty_res, w_empty_ok, "bad empty take")

    // a rejected push only happens at full capacity
    `KWM_ASSERT_IMPLIES(a_full_result, i_clk, i_rst_n, w_full_res, w_full_ok, "bad full push")

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the k-way merge min-heap core.
// A queue-based copy of the heap ordering predicts every result word: status,
// removed entry and occupancy. The stimulus is a short fixed opening, then
// merge runs, fill-to-full and drain-to-empty bursts, and random noise words.
// The sender and the receiver both stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int HEAP_DEPTH  = 64;
    localparam int WORD_GOAL   = 1350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 200;

    typedef struct {
        logic signed [kwm_pkg::DATA_W-1:0] value;
        logic [kwm_pkg::SRC_W-1:0]         source;
    } t_entry;

    typedef struct {
        logic [kwm_pkg::DATA_W-1:0] value;
        logic [kwm_pkg::SRC_W-1:0]  source;
        kwm_pkg::t_status           status;
        logic [kwm_pkg::OCC_W-1:0]  occupancy;
    } t_result;

    // Keeps the entries held, predicts each result word and checks it.
    // Entries equal in value and source cannot be told apart, so the
    // smallest entry of an unordered queue gives the same result as a heap.
    class heap_order_checker;
        t_entry                    held[$];
        t_result                   due_results[$];
        logic [kwm_pkg::SRC_W-1:0] last_taken_src;
        int mismatches, orphans, reported, checked;
        int n_full, n_empty, n_taken, peak;

        function bit ranks_before(t_entry a, t_entry b);
            if (a.value != b.value) return a.value < b.value;
            return a.source < b.source;
        endfunction

        function void note_word(kwm_pkg::t_opcode op, logic [kwm_pkg::DATA_W-1:0] value,
                                logic [kwm_pkg::SRC_W-1:0] source);
            t_result r;
            int best;
            r.value  = '0;
            r.source = '0;
            r.status = kwm_pkg::ST_OK;
            case (op)
                kwm_pkg::OP_CLEAR: held.delete();
                kwm_pkg::OP_PUSH: begin
                    if (held.size() >= HEAP_DEPTH) begin
                        r.status = kwm_pkg::ST_FULL;
                        n_full++;
                    end else begin
                        held.push_back('{value, source});
                    end
                end
                kwm_pkg::OP_TAKE: begin
                    if (held.size() == 0) begin
                        r.status = kwm_pkg::ST_EMPTY;
                        n_empty++;
                    end else begin
                        best = 0;
                        for (int i = 1; i < held.size(); i++)
                            if (ranks_before(held[i], held[best])) best = i;
                        r.value        = held[best].value;
                        r.source       = held[best].source;
                        last_taken_src = held[best].source;
                        held.delete(best);
                        n_taken++;
                    end
                end
                default: ;  // nop leaves the heap alone
            endcase
            r.occupancy = kwm_pkg::OCC_W'(held.size());
            if (held.size() > peak) peak = held.size();
            due_results.push_back(r);
        endfunction

        function void check_word(logic [kwm_pkg::DATA_W-1:0] value,
                                 logic [kwm_pkg::SRC_W-1:0] source,
                                 logic [kwm_pkg::ST_W-1:0] status,
                                 logic [kwm_pkg::OCC_W-1:0] occupancy);
            t_result want;
            checked++;
            if (due_results.size() == 0) begin
                orphans++;
                if (reported < 10) begin
                    reported++;
                    $display("%0t: unexpected result word value %0d source %0d",
                             $time, $signed(value), source);
                    $display("    status %0d occ %0d", status, occupancy);
                end
                return;
            end
            want = due_results.pop_front();
            if (value !== want.value || source !== want.source ||
                status !== want.status || occupancy !== want.occupancy) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display("%0t: mismatch (exp/got) value %0d/%0d source %0d/%0d",
                             $time, $signed(want.value), $signed(value),
                             want.source, source);
                    $display("    status %0d/%0d occ %0d/%0d",
                             want.status, status, want.occupancy, occupancy);
                end
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [kwm_pkg::OP_W-1:0]    i_opcode;
    logic [kwm_pkg::DATA_W-1:0]  i_value;
    logic [kwm_pkg::SRC_W-1:0]   i_source;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [kwm_pkg::DATA_W-1:0]  o_out_value;
    logic [kwm_pkg::SRC_W-1:0]   o_out_source;
    logic [kwm_pkg::ST_W-1:0]    o_status;
    logic [kwm_pkg::OCC_W-1:0]   o_occupancy;

    heap_order_checker sb = new();

    int  tx_idle_pct = 29;
    int  rx_idle_pct = 84;
    int  words_sent  = 0;
    int  cycle_count = 0;
    bit  hold_done   = 1'b0;
    int  merge_runs, fill_runs, noise_runs;

    // per-stream state of the merge run in progress
    int     stream_left [HEAP_DEPTH];
    longint stream_head [HEAP_DEPTH];

    k_way_merge_min_heap_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .i_source     (i_source),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_value  (o_out_value),
        .o_out_source (o_out_source),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: errors");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off so the core backs up
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && words_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word(o_out_value, o_out_source, o_status, o_occupancy);
    end

    // random source field
    function automatic logic [kwm_pkg::SRC_W-1:0] pick_source();
        return kwm_pkg::SRC_W'($urandom_range(63));
    endfunction

    // Offer one word and hold it until taken. Called right at a clock edge.
    task automatic send_word(kwm_pkg::t_opcode op, logic [kwm_pkg::DATA_W-1:0] value,
                             logic [kwm_pkg::SRC_W-1:0] source);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= value;
        i_source   <= source;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(op, value, source);
        words_sent++;
    endtask

    // extremes, near-zero values for ties, and plain random
    function automatic int pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -int'($urandom_range(1));
            3, 4, 5: return int'($urandom_range(20)) - 10;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic push_stream(int id, longint spread);
        longint nxt;
        send_word(kwm_pkg::OP_PUSH, stream_head[id][kwm_pkg::DATA_W-1:0],
                  kwm_pkg::SRC_W'(id));
        stream_left[id]--;
        nxt = stream_head[id] + longint'($urandom_range(int'(spread)));
        if (nxt > 64'sd2147483647) stream_left[id] = 0;
        else stream_head[id] = nxt;
    endtask

    // Well-formed merge: heads of every non-empty stream go in, then each take is
    // followed by the next element, if any, of the stream it came from.
    task automatic run_merge();
        int n_src, len_max, base, stride, id;
        longint spread;
        n_src   = ($urandom_range(3) == 0) ? $urandom_range(17, HEAP_DEPTH)
                                           : $urandom_range(1, 16);
        len_max = (n_src > 16) ? 3 : 6;
        base    = $urandom_range(HEAP_DEPTH - 1);
        stride  = 2 * $urandom_range(31) + 1;  // odd stride: distinct streams
        spread  = ($urandom_range(1) == 0) ? longint'($urandom_range(3))
                                           : longint'($urandom_range(32'h0100_0000));
        foreach (stream_left[j]) stream_left[j] = 0;
        for (int j = 0; j < n_src; j++) begin
            id = (base + j * stride) % HEAP_DEPTH;
            stream_left[id] = $urandom_range(len_max);
            stream_head[id] = longint'(pick_value());
        end
        send_word(kwm_pkg::OP_CLEAR, $urandom, pick_source());
        for (int j = 0; j < HEAP_DEPTH; j++)
            if (stream_left[j] > 0) push_stream(j, spread);
        while (sb.held.size() > 0) begin
            send_word(kwm_pkg::OP_TAKE, $urandom, pick_source());
            if (stream_left[sb.last_taken_src] > 0) push_stream(sb.last_taken_src, spread);
        end
        if ($urandom_range(3) == 0) send_word(kwm_pkg::OP_TAKE, $urandom, pick_source());
        merge_runs++;
    endtask

    // fill past capacity, then drain past empty with a few pushes mixed in
    task automatic run_fill();
        if ($urandom_range(1)) send_word(kwm_pkg::OP_CLEAR, $urandom, pick_source());
        while (sb.held.size() < HEAP_DEPTH)
            send_word(kwm_pkg::OP_PUSH, pick_value(), pick_source());
        repeat ($urandom_range(1, 3))
            send_word(kwm_pkg::OP_PUSH, pick_value(), pick_source());
        while (sb.held.size() > 0) begin
            if ($urandom_range(3) == 0) send_word(kwm_pkg::OP_PUSH, pick_value(), pick_source());
            else send_word(kwm_pkg::OP_TAKE, $urandom, pick_source());
        end
        repeat ($urandom_range(1, 2)) send_word(kwm_pkg::OP_TAKE, $urandom, pick_source());
        fill_runs++;
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 8))
            send_word(kwm_pkg::t_opcode'($urandom_range(3)), $urandom, pick_source());
        noise_runs++;
    endtask

    initial begin
        int seq_idx;
        int errors;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_opcode   = kwm_pkg::OP_NOP;
        i_value    = '0;
        i_source   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opening: empty take, extremes, ties, nop, clear
        send_word(kwm_pkg::OP_TAKE, 32'h0, 6'd0);
        send_word(kwm_pkg::OP_PUSH, 32'h7fff_ffff, 6'd63);
        send_word(kwm_pkg::OP_PUSH, 32'h8000_0000, 6'd0);
        send_word(kwm_pkg::OP_PUSH, 32'h0, 6'd5);
        send_word(kwm_pkg::OP_PUSH, 32'hffff_ffff, 6'd62);
        send_word(kwm_pkg::OP_PUSH, 32'd7, 6'd9);
        send_word(kwm_pkg::OP_PUSH, 32'd7, 6'd3);   // tie on value, lower source wins
        send_word(kwm_pkg::OP_PUSH, 32'd7, 6'd3);   // identical entry
        send_word(kwm_pkg::OP_NOP, 32'hdead_beef, 6'd42);
        repeat (8) send_word(kwm_pkg::OP_TAKE, 32'hffff_ffff, 6'd63);
        send_word(kwm_pkg::OP_PUSH, 32'd1, 6'd1);
        send_word(kwm_pkg::OP_CLEAR, 32'h5555_5555, 6'd21);
        send_word(kwm_pkg::OP_TAKE, 32'haaaa_aaaa, 6'd42);
        send_word(kwm_pkg::OP_NOP, 32'h0, 6'd0);
        send_word(kwm_pkg::OP_PUSH, -32'sd5, 6'd33);
        send_word(kwm_pkg::OP_CLEAR, 32'h0, 6'd0);

        // random part in three idling phases
        seq_idx = 0;
        while (words_sent < WORD_GOAL) begin
            if (words_sent < WORD_GOAL / 3) begin
                tx_idle_pct = 29;
                rx_idle_pct = 84;
            end else if (words_sent < 2 * WORD_GOAL / 3) begin
                tx_idle_pct = 84;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (seq_idx % 12 == 0) run_fill();
            else if ($urandom_range(9) < 8) run_merge();
            else run_noise();
            seq_idx++;
        end
        i_in_valid <= 1'b0;

        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        errors = sb.mismatches + sb.orphans + sb.due_results.size();
        $display("tb: %0d words in %0d merge runs, %0d fill bursts, %0d noise bursts",
                 words_sent, merge_runs, fill_runs, noise_runs);
        $display("tb: %0d results checked, %0d takes, %0d full pushes, %0d empty takes",
                 sb.checked, sb.n_taken, sb.n_full, sb.n_empty);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
